### hdl/tlbp_pkg.sv
// shared types, constants and helpers for the two-level branch predictor
package tlbp_pkg;

	localparam int unsigned MAX_ROWS    = 32;
	localparam int unsigned MAX_HISTORY = 8;
	localparam int unsigned PC_SHIFT    = 2;
	localparam int unsigned TAG_FULL    = 30;
	localparam int unsigned ROW_W       = $clog2(MAX_ROWS);
	localparam int unsigned CTR_AW      = ROW_W + MAX_HISTORY;
	localparam int unsigned CTR_DEPTH   = MAX_ROWS * (2 ** MAX_HISTORY);

	localparam logic [1:0] CTR_WEAK_NT = 2'b01;

	typedef enum logic [2:0] {
		REG_INDEX_BITS   = 3'd0,
		REG_HISTORY_BITS = 3'd1,
		REG_TAG_BITS     = 3'd2,
		REG_GLOBAL_HIST  = 3'd3,
		REG_GLOBAL_TABLE = 3'd4,
		REG_SHARE_XOR    = 3'd5
	} cfg_reg_t;

	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_LOOKUP,
		ST_WIPE
	} state_t;

	typedef struct packed {
		logic        func;
		logic [31:0] pc;
		logic [31:0] target_pc;
		logic        taken;
		logic [31:0] predicted_dst;
	} in_item_t;

	typedef struct packed {
		logic        predict_taken;
		logic [31:0] next_pc;
		logic [31:0] flush_count;
		logic [31:0] branch_count;
		logic [14:0] storage_bits;
	} out_item_t;

	typedef struct packed {
		logic [2:0] index_bits;
		logic [3:0] history_bits;
		logic [4:0] tag_bits;
		logic       global_history;
		logic       global_table;
		logic       share_xor;
	} cfg_t;

	// counter memory request between controller and counter store
	typedef struct packed {
		logic              rd_en;
		logic [CTR_AW-1:0] rd_addr;
		logic              wr_en;
		logic [CTR_AW-1:0] wr_addr;
		logic [1:0]        wr_data;
	} ctr_req_t;

	function automatic logic [31:0] low_mask(input logic [5:0] n);
		logic [31:0] m;
		m = '0;
		for (int i = 0; i < 32; i++) begin
			if (i < n) m[i] = 1'b1;
		end
		return m;
	endfunction

	function automatic logic [2:0] eff_index(input logic [2:0] v);
		return (v > 3'd5) ? 3'd5 : v;
	endfunction

	function automatic logic [3:0] eff_hist(input logic [3:0] v);
		if (v < 4'd1) return 4'd1;
		if (v > 4'(MAX_HISTORY)) return 4'(MAX_HISTORY);
		return v;
	endfunction

	function automatic logic [4:0] eff_tag(input logic [4:0] v);
		return (v > 5'(TAG_FULL)) ? 5'(TAG_FULL) : v;
	endfunction

endpackage

### hdl/two_level_branch_predictor.sv
// top level of the two-level branch predictor with target buffer
//
// in channel (in_valid/in_ready/in_data) takes one beat per predict or
// update request; out channel (out_valid/out_ready/out_data) returns one
// beat per request with direction, next pc, counters and storage size.
// cfg channel (cfg_valid/cfg_ready/cfg_index/cfg_data) writes the six
// configuration registers; write only while no request is in flight.
// a request passes through its steps in order: the accept cycle reads the
// row memory, the lookup reads the counter memory, and the last step forms
// the result in the output register and writes back. a new request is
// taken only once the last has finished. an update that misses its tag
// with per-row tables rewrites that row's 256 counters, one per cycle,
// before it finishes; the counter memory's single write port sets this rate.
// after reset all 8192 counter entries and the row memory are swept to
// their reset values while in_ready stays low; cfg writes are taken.
// the output register holds one finished result while out_ready is low;
// the next request is still taken and waits in its last step, without
// writing back, until that beat has left.
module two_level_branch_predictor (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  tlbp_pkg::in_item_t  in_data,
	output logic                out_valid,
	input  logic                out_ready,
	output tlbp_pkg::out_item_t out_data,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [2:0]          cfg_index,
	input  logic [31:0]         cfg_data
);
	import tlbp_pkg::*;

	cfg_t cfg_q;
	state_t state_q, state_d;
	logic [CTR_AW-1:0] sweep_q, sweep_d;
	in_item_t item_q;
	logic [31:0] flush_q, branch_q;
	logic [7:0] shist_q;
	out_item_t out_q;
	logic out_valid_q;
	logic out_free;

	// derived per-item fields
	logic [2:0]  ei;
	logic [3:0]  eh;
	logic [31:0] hmask;
	logic [ROW_W-1:0] row;
	logic [29:0] tag;
	logic [69:0] row_rd;
	logic [29:0] r_tag;
	logic [31:0] r_tgt;
	logic [7:0]  r_hist;
	logic        hit;
	logic [7:0]  hist;
	logic [7:0]  place;
	logic [ROW_W-1:0] tbl;
	logic [1:0]  ctr_rd;
	logic [1:0]  ctr_new;
	logic        mispredict;
	logic [31:0] pc4;
	logic        wipe;
	logic [14:0] storage;
	ctr_req_t    creq;
	logic        row_rd_en, row_wr_en;
	logic [ROW_W-1:0] row_rd_addr, row_wr_addr;
	logic [69:0] row_wr_data;
	logic [7:0]  new_row_hist;
	logic        upd_done;

	assign cfg_ready = 1'b1;
	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;
	assign out_data  = out_q;
	// output register can take a new beat this cycle
	assign out_free  = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '{index_bits: 3'd4, history_bits: 4'd4, tag_bits: 5'd8,
				global_history: 1'b0, global_table: 1'b0, share_xor: 1'b0};
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_INDEX_BITS:   cfg_q.index_bits     <= cfg_data[2:0];
				REG_HISTORY_BITS: cfg_q.history_bits   <= cfg_data[3:0];
				REG_TAG_BITS:     cfg_q.tag_bits       <= cfg_data[4:0];
				REG_GLOBAL_HIST:  cfg_q.global_history <= cfg_data[0];
				REG_GLOBAL_TABLE: cfg_q.global_table   <= cfg_data[0];
				REG_SHARE_XOR:    cfg_q.share_xor      <= cfg_data[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		ei    = eff_index(cfg_q.index_bits);
		eh    = eff_hist(cfg_q.history_bits);
		hmask = low_mask(6'(eh));
		row   = ROW_W'((item_q.pc >> PC_SHIFT) & low_mask(6'(ei)));
		tag   = 30'((item_q.pc >> PC_SHIFT) & low_mask(6'(eff_tag(cfg_q.tag_bits))));
		{r_tag, r_tgt, r_hist} = row_rd;
		hit   = (tag == r_tag);
		hist  = (cfg_q.global_history ? shist_q : r_hist) & hmask[7:0];
		if (item_q.func && !hit && !cfg_q.global_history) hist = '0;
		place = cfg_q.share_xor ? (hist ^ 8'((item_q.pc >> PC_SHIFT) & hmask)) : hist;
		tbl   = cfg_q.global_table ? '0 : row;
		pc4   = item_q.pc + 32'd4;
		mispredict = item_q.taken ? (item_q.predicted_dst != item_q.target_pc)
			: (item_q.predicted_dst != pc4);
		wipe = item_q.func && !hit && !cfg_q.global_table;
		// wiped table reads as weak not taken
		ctr_new = wipe ? CTR_WEAK_NT : ctr_rd;
		if (item_q.taken) begin
			if (ctr_new != 2'd3) ctr_new = ctr_new + 2'd1;
		end else begin
			if (ctr_new != 2'd0) ctr_new = ctr_new - 2'd1;
		end
		new_row_hist = cfg_q.global_history ? r_hist
			: {((item_q.func && !hit) ? 8'd0 : r_hist)} << 1 | 8'(item_q.taken);
	end

	// storage size from the configuration formula
	always_comb begin
		logic [5:0]  r;
		logic [9:0]  c;
		logic [5:0]  base;
		logic [31:0] s;
		r    = 6'd1 << ei;
		c    = 10'd2 << eh;
		base = 6'(eff_tag(cfg_q.tag_bits)) + 6'(TAG_FULL);
		if (!cfg_q.global_table && !cfg_q.global_history)
			s = 32'(r) * (32'(base) + 32'(eh) + 32'(c));
		else if (cfg_q.global_table && cfg_q.global_history)
			s = 32'(r) * 32'(base) + 32'(eh) + 32'(c);
		else if (cfg_q.global_table)
			s = 32'(r) * (32'(base) + 32'(eh)) + 32'(c);
		else
			s = 32'(r) * (32'(base) + 32'(c)) + 32'(eh);
		storage = s[14:0];
	end

	always_comb begin
		state_d     = state_q;
		sweep_d     = sweep_q;
		creq        = '0;
		row_rd_en   = 1'b0;
		row_rd_addr = ROW_W'((in_data.pc >> PC_SHIFT) & low_mask(6'(ei)));
		row_wr_en   = 1'b0;
		row_wr_addr = row;
		row_wr_data = {tag, item_q.target_pc, new_row_hist};
		upd_done    = 1'b0;
		unique case (state_q)
			ST_CLEAR: begin
				creq.wr_en   = 1'b1;
				creq.wr_addr = sweep_q;
				creq.wr_data = CTR_WEAK_NT;
				row_wr_en    = 1'b1;
				row_wr_addr  = sweep_q[ROW_W-1:0];
				row_wr_data  = '0;
				sweep_d      = sweep_q + 1'b1;
				if (&sweep_q) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (in_valid && in_ready) begin
					row_rd_en = 1'b1;
					state_d   = ST_LOOKUP;
				end
			end
			ST_LOOKUP: begin
				// counter read happens this cycle via the row read result
				creq.rd_en   = 1'b1;
				creq.rd_addr = {tbl, place};
				state_d      = ST_WIPE;
				sweep_d      = '0;
			end
			ST_WIPE: begin
				if (wipe && sweep_q[MAX_HISTORY] == 1'b0) begin
					creq.wr_en   = 1'b1;
					creq.wr_addr = {row, sweep_q[MAX_HISTORY-1:0]};
					creq.wr_data = (sweep_q[MAX_HISTORY-1:0] == place) ? ctr_new : CTR_WEAK_NT;
					sweep_d      = sweep_q + 1'b1;
				end else if (out_free) begin
					if (item_q.func) begin
						if (!wipe) begin
							creq.wr_en   = 1'b1;
							creq.wr_addr = {tbl, place};
							creq.wr_data = ctr_new;
						end
						row_wr_en = 1'b1;
					end
					upd_done = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			sweep_q     <= '0;
			flush_q     <= '0;
			branch_q    <= '0;
			shist_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			sweep_q <= sweep_d;
			if (upd_done) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
			if (upd_done) begin
				if (item_q.func) begin
					branch_q <= branch_q + 32'd1;
					if (mispredict) flush_q <= flush_q + 32'd1;
					if (cfg_q.global_history) shist_q <= {shist_q[6:0], item_q.taken};
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) item_q <= in_data;
		if (upd_done) begin
			out_q.predict_taken <= !item_q.func && hit && ctr_rd[1];
			out_q.next_pc       <= item_q.func ? 32'd0
				: ((hit && ctr_rd[1]) ? r_tgt : pc4);
			out_q.flush_count   <= flush_q + 32'(item_q.func && mispredict);
			out_q.branch_count  <= branch_q + 32'(item_q.func);
			out_q.storage_bits  <= storage;
		end
	end

	tlbp_row_ram u_row (
		.clk     (clk),
		.rd_en   (row_rd_en),
		.rd_addr (row_rd_addr),
		.wr_en   (row_wr_en),
		.wr_addr (row_wr_addr),
		.wr_data (row_wr_data),
		.rd_data (row_rd)
	);

	tlbp_ctr_ram u_ctr (
		.clk     (clk),
		.req     (creq),
		.rd_data (ctr_rd)
	);

	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_IDLE) |-> !in_ready) else $error("accept while busy");
	a_result_after_work: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q) == ST_WIPE) else $error("stray result");
	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		(branch_q != $past(branch_q)) |-> $past(upd_done)) else $error("count moved");

endmodule

### hdl/tlbp_ctr_ram.sv
// 2-bit direction counter memory, one read and one write port
module tlbp_ctr_ram (
	input  logic               clk,
	input  tlbp_pkg::ctr_req_t req,
	output logic [1:0]         rd_data
);
	import tlbp_pkg::*;

	logic [1:0] mem [CTR_DEPTH];

	always_ff @(posedge clk) begin
		if (req.wr_en) mem[req.wr_addr] <= req.wr_data;
		if (req.rd_en) rd_data <= mem[req.rd_addr];
	end

endmodule

### hdl/tlbp_row_ram.sv
// per-row tag, target and history memory with registered read
module tlbp_row_ram (
	input  logic                           clk,
	input  logic                           rd_en,
	input  logic [tlbp_pkg::ROW_W-1:0]     rd_addr,
	input  logic                           wr_en,
	input  logic [tlbp_pkg::ROW_W-1:0]     wr_addr,
	input  logic [69:0]                    wr_data,
	output logic [69:0]                    rd_data
);
	import tlbp_pkg::*;

	logic [69:0] mem [MAX_ROWS];

	always_ff @(posedge clk) begin
		if (wr_en) mem[wr_addr] <= wr_data;
		if (rd_en) rd_data <= mem[rd_addr];
	end

endmodule

### sim/two_level_branch_predictor_tb.sv
// self-checking testbench for the two-level branch predictor with target buffer
module two_level_branch_predictor_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import tlbp_pkg::*;

	class branch_scoreboard;
		logic [2:0] idx_bits;
		logic [3:0] hist_bits;
		logic [4:0] tg_bits;
		logic       glob_hist, glob_tbl, use_xor;
		logic [29:0] tags [MAX_ROWS];
		logic [31:0] targets [MAX_ROWS];
		logic [7:0]  row_hist [MAX_ROWS];
		logic [7:0]  glob_hreg;
		logic [1:0]  ctrs [CTR_DEPTH];
		logic [31:0] miss_total, upd_total;
		out_item_t   pending [$];
		int          mismatches;
		int          checked;

		function new();
			idx_bits = 4; hist_bits = 4; tg_bits = 8;
			glob_hist = 0; glob_tbl = 0; use_xor = 0;
			foreach (tags[i]) begin
				tags[i] = '0; targets[i] = '0; row_hist[i] = '0;
			end
			foreach (ctrs[i]) ctrs[i] = CTR_WEAK_NT;
			glob_hreg = '0; miss_total = '0; upd_total = '0;
			mismatches = 0; checked = 0;
		endfunction

		function void write_reg(cfg_reg_t r, logic [31:0] v);
			case (r)
				REG_INDEX_BITS:   idx_bits = v[2:0];
				REG_HISTORY_BITS: hist_bits = v[3:0];
				REG_TAG_BITS:     tg_bits = v[4:0];
				REG_GLOBAL_HIST:  glob_hist = v[0];
				REG_GLOBAL_TABLE: glob_tbl = v[0];
				REG_SHARE_XOR:    use_xor = v[0];
				default: ;
			endcase
		endfunction

		function int unsigned hist_len();
			if (hist_bits < 1) return 1;
			if (hist_bits > MAX_HISTORY) return MAX_HISTORY;
			return hist_bits;
		endfunction

		function logic [31:0] mask_of(int unsigned n);
			return (n >= 32) ? 32'hffff_ffff : ((32'd1 << n) - 1);
		endfunction

		function logic [14:0] storage();
			int unsigned r, h, c, base, s;
			r = 1 << ((idx_bits > 5) ? 5 : idx_bits);
			h = hist_len();
			c = 2 << h;
			base = ((tg_bits > TAG_FULL) ? TAG_FULL : tg_bits) + TAG_FULL;
			if (!glob_tbl && !glob_hist) s = r * (base + h + c);
			else if (glob_tbl && glob_hist) s = r * base + h + c;
			else if (glob_tbl) s = r * (base + h) + c;
			else s = r * (base + c) + h;
			return s[14:0];
		endfunction

		// works out the result of one accepted request and advances the state
		function void note_request(in_item_t it);
			int unsigned h, row, tbl, ci;
			logic [31:0] word, tag, hist, place, pc4;
			logic hit;
			out_item_t e;
			h = hist_len();
			word = it.pc >> PC_SHIFT;
			row = word & mask_of((idx_bits > 5) ? 5 : idx_bits);
			tag = word & mask_of((tg_bits > TAG_FULL) ? TAG_FULL : tg_bits);
			hit = (tag[29:0] == tags[row]);
			hist = (glob_hist ? glob_hreg : row_hist[row]) & mask_of(h);
			tbl = glob_tbl ? 0 : row;
			pc4 = it.pc + 32'd4;
			e = '0;
			if (!it.func) begin
				place = use_xor ? (hist ^ (word & mask_of(h))) : hist;
				ci = tbl * 256 + place[7:0];
				if (hit && ctrs[ci] >= 2) begin
					e.predict_taken = 1; e.next_pc = targets[row];
				end else e.next_pc = pc4;
			end else begin
				if (!hit) begin
					if (!glob_hist) begin row_hist[row] = 0; hist = 0; end
					if (!glob_tbl) for (int i = 0; i < 256; i++) ctrs[row*256+i] = CTR_WEAK_NT;
				end
				if ((it.taken && it.predicted_dst != it.target_pc) ||
				    (!it.taken && it.predicted_dst != pc4)) miss_total++;
				upd_total++;
				place = use_xor ? (hist ^ (word & mask_of(h))) : hist;
				ci = tbl * 256 + place[7:0];
				if (it.taken) begin if (ctrs[ci] < 3) ctrs[ci]++; end
				else begin if (ctrs[ci] > 0) ctrs[ci]--; end
				if (glob_hist) glob_hreg = {glob_hreg[6:0], it.taken};
				else row_hist[row] = {row_hist[row][6:0], it.taken};
				targets[row] = it.target_pc;
				tags[row] = tag[29:0];
			end
			e.flush_count = miss_total;
			e.branch_count = upd_total;
			e.storage_bits = storage();
			pending.push_back(e);
		endfunction

		function void check_result(out_item_t got);
			out_item_t w;
			checked++;
			if (pending.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected result beat %p", got);
				return;
			end
			w = pending.pop_front();
			if (got.predict_taken !== w.predict_taken || got.next_pc !== w.next_pc ||
			    got.flush_count !== w.flush_count || got.branch_count !== w.branch_count ||
			    got.storage_bits !== w.storage_bits) begin
				mismatches++;
				if (mismatches <= 10)
					$display("mismatch: expected %p got %p", w, got);
			end
		endfunction
	endclass

	logic clk, arst_n;
	logic in_valid, in_ready, out_valid, out_ready, cfg_valid, cfg_ready;
	in_item_t in_data;
	out_item_t out_data;
	logic [2:0] cfg_index;
	logic [31:0] cfg_data;
	branch_scoreboard sb;
	int send_idle, recv_stall;
	bit hold_off;
	int n_sent;

	two_level_branch_predictor dut (.*);

	initial begin
		clk = 0;
		forever #4 clk = ~clk;
	end

	initial begin
		#30ms;
		$display("FAIL two_level_branch_predictor");
		$finish;
	end

	// receiver: stalls at the phase's rate, or for a long stretch when held off
	initial begin
		out_ready = 0;
		forever begin
			@(negedge clk);
			if (hold_off) begin
				out_ready <= 0;
				repeat (400) @(negedge clk);
				hold_off = 0;
			end
			out_ready <= ($urandom_range(99) >= recv_stall);
		end
	end

	always @(posedge clk) if (arst_n && out_valid && out_ready) sb.check_result(out_data);

	// called at a falling edge; returns at the falling edge after the accepting beat
	task automatic send_request(in_item_t it);
		while ($urandom_range(99) < send_idle) begin
			in_valid <= 0;
			@(negedge clk);
		end
		in_valid <= 1;
		in_data <= it;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		sb.note_request(it);
		n_sent++;
		@(negedge clk);
	endtask

	task automatic drain();
		in_valid <= 0;
		while (sb.pending.size() != 0) @(negedge clk);
		repeat (300) @(negedge clk);
	endtask

	task automatic write_cfg(cfg_reg_t r, logic [31:0] v);
		cfg_valid <= 1;
		cfg_index <= r;
		cfg_data <= v;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		sb.write_reg(r, v);
		@(negedge clk);
	endtask

	task automatic set_all(logic [31:0] ib, hb, tb, gh, gt, sx);
		write_cfg(REG_INDEX_BITS, ib);
		write_cfg(REG_HISTORY_BITS, hb);
		write_cfg(REG_TAG_BITS, tb);
		write_cfg(REG_GLOBAL_HIST, gh);
		write_cfg(REG_GLOBAL_TABLE, gt);
		write_cfg(REG_SHARE_XOR, sx);
		cfg_valid <= 0;
	endtask

	function automatic in_item_t make_branch(logic fn, logic [31:0] pc);
		in_item_t it;
		it.func = fn;
		it.pc = pc;
		it.target_pc = $urandom;
		it.taken = $urandom_range(1);
		case ($urandom_range(3))
			0: it.predicted_dst = $urandom;
			1: it.predicted_dst = it.target_pc;
			default: it.predicted_dst = pc + 32'd4;
		endcase
		return it;
	endfunction

	// random traffic: mostly a small working set of branches, each request randomly a prediction or an update
	task automatic random_phase(int count);
		logic [31:0] pool [8];
		in_item_t it;
		foreach (pool[i]) pool[i] = $urandom & ((i < 6) ? 32'h0000_03ff : 32'hffff_ffff);
		for (int i = 0; i < count; i++) begin
			if ($urandom_range(9) == 0) it = make_branch($urandom_range(1), $urandom);
			else it = make_branch($urandom_range(1), pool[$urandom_range(7)]);
			send_request(it);
		end
	endtask

	initial begin
		in_item_t it;
		sb = new();
		arst_n = 0; in_valid = 0; in_data = '0; cfg_valid = 0; cfg_index = '0;
		cfg_data = '0; send_idle = 0; recv_stall = 0; hold_off = 0; n_sent = 0;
		repeat (9) @(negedge clk);
		arst_n = 1;
		@(negedge clk);
		// directed: extremes, hits, misses, counters saturating both ways
		send_request('{1'b0, 32'h0, 32'h0, 1'b0, 32'h0});
		send_request('{1'b1, 32'hffff_ffff, 32'hffff_ffff, 1'b1, 32'h0});
		send_request('{1'b0, 32'hffff_ffff, 32'h0, 1'b0, 32'h0});
		for (int i = 0; i < 4; i++)
			send_request('{1'b1, 32'h40, 32'h1234_5678, 1'b1, 32'h1234_5678});
		send_request('{1'b0, 32'h40, 32'h0, 1'b0, 32'h0});
		send_request('{1'b1, 32'h40, 32'h0, 1'b0, 32'h44});
		send_request('{1'b1, 32'h840, 32'haaaa_5555, 1'b1, 32'h844});
		send_request('{1'b0, 32'h840, 32'h0, 1'b1, 32'hffff_ffff});
		for (int i = 0; i < 3; i++)
			send_request('{1'b1, 32'h80, 32'h5555_aaaa, 1'b0, 32'h0});
		send_request('{1'b0, 32'h80, 32'h0, 1'b0, 32'h0});
		drain();
		for (int ph = 0; ph < 8; ph++) begin
			case (ph)
				0: set_all(0, 0, 0, 1, 1, 1);
				1: set_all(7, 15, 31, 0, 0, 1);
				2: set_all(5, 8, 30, 1, 0, 0);
				3: set_all(2, 1, 3, 0, 1, 1);
				default: set_all($urandom_range(7), $urandom_range(15), $urandom_range(31),
				                 $urandom_range(1), $urandom_range(1), $urandom_range(1));
			endcase
			case (ph % 4)
				0: begin send_idle = 0;  recv_stall = 0;  end
				1: begin send_idle = 62; recv_stall = 0;  end
				2: begin send_idle = 0;  recv_stall = 62; end
				default: begin send_idle = 14; recv_stall = 14; end
			endcase
			if (ph == 2) hold_off = 1;
			random_phase(180);
			drain();
		end
		$display("covered %0d requests, %0d results over 9 register settings",
		         n_sent, sb.checked);
		if (sb.mismatches == 0 && sb.pending.size() == 0)
			$display("PASS two_level_branch_predictor");
		else
			$display("FAIL two_level_branch_predictor");
		$finish;
	end
endmodule

### two_level_branch_predictor.f
hdl/tlbp_pkg.sv
hdl/tlbp_ctr_ram.sv
hdl/tlbp_row_ram.sv
hdl/two_level_branch_predictor.sv
sim/two_level_branch_predictor_tb.sv
